/* design/swan_pkg.sv */
// ----------------------------------------------------------------------------
// swan_pkg: shared types and codes for the sliding-window ACK/NAK controller
// Event kinds, request kinds, configuration register indexes and widths.
// ----------------------------------------------------------------------------
package swan_pkg;

  localparam int SEQ_W = 32;
  localparam int WIN_W = 7;
  localparam int ALU_W = 34;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [SEQ_W:0]   len_t;
  typedef logic [WIN_W-1:0] win_t;
  typedef logic [ALU_W-1:0] alu_t;
  typedef logic [1:0]       op_t;
  typedef logic [1:0]       kind_t;
  typedef logic [1:0]       cfg_idx_t;

  // Event kinds on the input channel
  localparam op_t OP_ACK = 2'd0;
  localparam op_t OP_NAK = 2'd1;

  // Request kinds on the result channel
  localparam kind_t KIND_SEND = 2'd0;
  localparam kind_t KIND_RETX = 2'd1;
  localparam kind_t KIND_BAD  = 2'd2;

  // Configuration register indexes
  localparam cfg_idx_t CFG_FIRST_SEQ  = 2'd0;
  localparam cfg_idx_t CFG_DATA_COUNT = 2'd1;
  localparam cfg_idx_t CFG_MIN_WIN    = 2'd2;
  localparam cfg_idx_t CFG_MAX_WIN    = 2'd3;

  localparam win_t MAX_OUT  = 7'd64;
  localparam seq_t NONE_YET = 32'hFFFF_FFFF;

endpackage

/* design/sliding_window_ack_nak_control.sv */
// ----------------------------------------------------------------------------
// sliding_window_ack_nak_control
// Sender-side sliding-window controller: turns ACK/NAK events into send and
// retransmit requests and keeps the last acked number and the window size.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one ACK, NAK or bad-kind event.
//   Result channel (out_valid/out_stall) carries the requests it causes, zero
//   to 64 per event, with out_last set on the final one. The user must see
//   that registers are written through cfg_we/cfg_index/cfg_data only while
//   no event is in progress; the block itself does not enforce it. Each
//   event runs through a small sequencer that drives one shared 34-bit
//   add/subtract unit; a NAK and an ACK (in order or with a gap) do their
//   own setup steps before the total and cap steps that a bad kind starts
//   at. Requests leave at one per cycle, while the receiver does not stall,
//   from a single output register, and in_stall stays high until the last
//   is loaded. An event with no requests frees the input after its setup.
//   A stalled receiver holds the output register and the sequencer waits.
//   Reset (synchronous, rst_n low) restores the register defaults, marks
//   nothing acked yet and sets the window to zero.
// ----------------------------------------------------------------------------
module sliding_window_ack_nak_control #(
  parameter int WINDOW_LIMIT = 64,
  parameter int BURST_LIMIT  = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  swan_pkg::op_t            in_operation,
  input  swan_pkg::seq_t           in_ack_seq,
  output logic                     out_valid,
  input  logic                     out_stall,
  output swan_pkg::kind_t          out_request_kind,
  output swan_pkg::seq_t           out_request_seq,
  output swan_pkg::win_t           out_window_now,
  output logic                     out_truncated,
  output logic                     out_last,
  input  logic                     cfg_we,
  input  swan_pkg::cfg_idx_t       cfg_index,
  input  swan_pkg::seq_t           cfg_data
);

  localparam swan_pkg::win_t WIN_CAP =
    (WINDOW_LIMIT > 127) ? 7'd127 : swan_pkg::WIN_W'(WINDOW_LIMIT);
  localparam swan_pkg::win_t BURST_CAP =
    (BURST_LIMIT > 64) ? swan_pkg::MAX_OUT : swan_pkg::WIN_W'(BURST_LIMIT);

  localparam swan_pkg::alu_t ALU_ONE = swan_pkg::alu_t'(1);
  localparam swan_pkg::alu_t SPAN    = swan_pkg::alu_t'(64'h1_0000_0000);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_ACK_INC = 5'd1;
  localparam logic [4:0] ST_ACK_CHK = 5'd2;
  localparam logic [4:0] ST_G_END   = 5'd3;
  localparam logic [4:0] ST_G_B1    = 5'd4;
  localparam logic [4:0] ST_G_HIA   = 5'd5;
  localparam logic [4:0] ST_G_LENA  = 5'd6;
  localparam logic [4:0] ST_G_LOB   = 5'd7;
  localparam logic [4:0] ST_G_HIB   = 5'd8;
  localparam logic [4:0] ST_G_LENB  = 5'd9;
  localparam logic [4:0] ST_S_D0A   = 5'd10;
  localparam logic [4:0] ST_S_D0B   = 5'd11;
  localparam logic [4:0] ST_S_END   = 5'd12;
  localparam logic [4:0] ST_S_MIN   = 5'd13;
  localparam logic [4:0] ST_S_LEN1  = 5'd14;
  localparam logic [4:0] ST_S_ST1   = 5'd15;
  localparam logic [4:0] ST_S_LEN2  = 5'd16;
  localparam logic [4:0] ST_N_DIF   = 5'd17;
  localparam logic [4:0] ST_N_CHK   = 5'd18;
  localparam logic [4:0] ST_TOT     = 5'd19;
  localparam logic [4:0] ST_CAP     = 5'd20;
  localparam logic [4:0] ST_EMIT    = 5'd21;

  function automatic swan_pkg::win_t clamp_win(input logic [7:0] w,
                                               input swan_pkg::win_t lo_cfg,
                                               input swan_pkg::win_t hi_cfg);
    swan_pkg::win_t hi;
    swan_pkg::win_t lo;
    hi = (hi_cfg > WIN_CAP) ? WIN_CAP : hi_cfg;
    lo = (lo_cfg > hi) ? hi : lo_cfg;
    if (w > {1'b0, hi}) begin
      clamp_win = hi;
    end else if (w < {1'b0, lo}) begin
      clamp_win = lo;
    end else begin
      clamp_win = w[6:0];
    end
  endfunction

  // configuration
  swan_pkg::seq_t first_seq_r,  first_seq_nxt;
  swan_pkg::seq_t data_count_r, data_count_nxt;
  swan_pkg::win_t min_win_r,    min_win_nxt;
  swan_pkg::win_t max_win_r,    max_win_nxt;

  // protocol state
  swan_pkg::seq_t last_acked_r, last_acked_nxt;
  swan_pkg::win_t win_r,        win_nxt;

  // sequencer
  logic [4:0]      state_r, state_nxt;
  swan_pkg::seq_t  seq_r, seq_nxt;
  swan_pkg::kind_t kind_r, kind_nxt;
  logic            gap_r, gap_nxt;
  logic            trunc_r, trunc_nxt;
  swan_pkg::alu_t  t0_r, t0_nxt;
  swan_pkg::alu_t  t1_r, t1_nxt;
  swan_pkg::len_t  end_r, end_nxt;
  swan_pkg::len_t  b1_r, b1_nxt;
  swan_pkg::len_t  len1_r, len1_nxt;
  swan_pkg::len_t  len2_r, len2_nxt;
  swan_pkg::seq_t  start1_r, start1_nxt;
  swan_pkg::seq_t  start2_r, start2_nxt;
  swan_pkg::seq_t  cur_r, cur_nxt;
  swan_pkg::win_t  out_left_r, out_left_nxt;
  swan_pkg::win_t  run1_left_r, run1_left_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  swan_pkg::kind_t out_kind_r, out_kind_nxt;
  swan_pkg::seq_t  out_seq_r, out_seq_nxt;
  swan_pkg::win_t  out_win_r, out_win_nxt;
  logic            out_trunc_r, out_trunc_nxt;
  logic            out_last_r, out_last_nxt;

  // shared add/subtract unit
  swan_pkg::alu_t alu_a;
  swan_pkg::alu_t alu_b;
  logic           alu_sub;
  swan_pkg::alu_t alu_y;
  logic           alu_neg;

  swan_pkg::alu_t phi_a;
  swan_pkg::alu_t phi_b;
  swan_pkg::win_t cap_w;
  swan_pkg::win_t n_sel;
  logic           in_acc;
  logic           out_load;

  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // upper end of the wrapped piece and of the unwrapped piece (or window end)
  assign phi_a = end_r[32] ? {2'b00, end_r[31:0]} : '0;
  assign phi_b = end_r[32] ? SPAN : {1'b0, end_r};
  assign cap_w = gap_r ? BURST_CAP : swan_pkg::MAX_OUT;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r) inside
      ST_ACK_INC: begin
        alu_a = {2'b00, last_acked_r};
        alu_b = ALU_ONE;
      end
      ST_ACK_CHK: begin
        alu_a   = t0_r;
        alu_b   = {2'b00, seq_r};
        alu_sub = 1'b1;
      end
      ST_G_END: begin
        alu_a = {2'b00, first_seq_r};
        alu_b = {2'b00, data_count_r};
      end
      ST_G_B1, ST_S_ST1: begin
        alu_a = {2'b00, seq_r};
        alu_b = ALU_ONE;
      end
      ST_G_HIA: begin
        alu_a   = phi_a;
        alu_b   = {1'b0, b1_r};
        alu_sub = 1'b1;
      end
      ST_G_LENA: begin
        alu_a   = t0_r;
        alu_b   = {2'b00, last_acked_r};
        alu_sub = 1'b1;
      end
      ST_G_LOB: begin
        alu_a   = {2'b00, first_seq_r};
        alu_b   = {2'b00, last_acked_r};
        alu_sub = 1'b1;
      end
      ST_G_HIB: begin
        alu_a   = phi_b;
        alu_b   = {1'b0, b1_r};
        alu_sub = 1'b1;
      end
      ST_G_LENB: begin
        alu_a   = t0_r;
        alu_b   = {2'b00, start2_r};
        alu_sub = 1'b1;
      end
      ST_S_D0A, ST_N_DIF: begin
        alu_a   = {2'b00, seq_r};
        alu_b   = {2'b00, first_seq_r};
        alu_sub = 1'b1;
      end
      ST_S_D0B: begin
        alu_a = t0_r;
        alu_b = ALU_ONE;
      end
      ST_S_END: begin
        alu_a = t0_r;
        alu_b = {27'd0, win_r};
      end
      ST_S_MIN: begin
        alu_a   = phi_b;
        alu_b   = {2'b00, data_count_r};
        alu_sub = 1'b1;
      end
      ST_S_LEN1: begin
        alu_a   = t1_r;
        alu_b   = t0_r;
        alu_sub = 1'b1;
      end
      ST_S_LEN2: begin
        alu_a   = {2'b00, end_r[31:0]};
        alu_b   = {2'b00, data_count_r};
        alu_sub = 1'b1;
      end
      ST_N_CHK: begin
        alu_a   = t0_r;
        alu_b   = {2'b00, data_count_r};
        alu_sub = 1'b1;
      end
      ST_TOT: begin
        alu_a = {1'b0, len1_r};
        alu_b = {1'b0, len2_r};
      end
      ST_CAP: begin
        alu_a   = {27'd0, cap_w};
        alu_b   = t1_r;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_y   = alu_a + (alu_sub ? ~alu_b : alu_b) + {33'd0, alu_sub};
  assign alu_neg = alu_y[swan_pkg::ALU_W-1];
  assign n_sel   = alu_neg ? cap_w : t1_r[6:0];

  always_comb begin
    first_seq_nxt  = first_seq_r;
    data_count_nxt = data_count_r;
    min_win_nxt    = min_win_r;
    max_win_nxt    = max_win_r;
    last_acked_nxt = last_acked_r;
    win_nxt        = win_r;
    state_nxt      = state_r;
    seq_nxt        = seq_r;
    kind_nxt       = kind_r;
    gap_nxt        = gap_r;
    trunc_nxt      = trunc_r;
    t0_nxt         = t0_r;
    t1_nxt         = t1_r;
    end_nxt        = end_r;
    b1_nxt         = b1_r;
    len1_nxt       = len1_r;
    len2_nxt       = len2_r;
    start1_nxt     = start1_r;
    start2_nxt     = start2_r;
    cur_nxt        = cur_r;
    out_left_nxt   = out_left_r;
    run1_left_nxt  = run1_left_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_seq_nxt    = out_seq_r;
    out_win_nxt    = out_win_r;
    out_trunc_nxt  = out_trunc_r;
    out_last_nxt   = out_last_r;

    if (cfg_we) begin
      unique case (cfg_index)
        swan_pkg::CFG_FIRST_SEQ:  first_seq_nxt  = cfg_data;
        swan_pkg::CFG_DATA_COUNT: data_count_nxt = cfg_data;
        swan_pkg::CFG_MIN_WIN:    min_win_nxt    = cfg_data[6:0];
        swan_pkg::CFG_MAX_WIN:    max_win_nxt    = cfg_data[6:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          seq_nxt = in_ack_seq;
          gap_nxt = 1'b0;
          unique case (in_operation)
            swan_pkg::OP_ACK: begin
              state_nxt = ST_ACK_INC;
            end
            swan_pkg::OP_NAK: begin
              kind_nxt  = swan_pkg::KIND_RETX;
              state_nxt = ST_N_DIF;
            end
            default: begin
              kind_nxt   = swan_pkg::KIND_BAD;
              start1_nxt = '0;
              start2_nxt = '0;
              len1_nxt   = swan_pkg::len_t'(1);
              len2_nxt   = '0;
              state_nxt  = ST_TOT;
            end
          endcase
        end
      end
      ST_ACK_INC: begin
        t0_nxt    = alu_y;
        state_nxt = ST_ACK_CHK;
      end
      ST_ACK_CHK: begin
        // last_acked + 1 < ack_seq means a gap; none-yet never qualifies
        if (alu_neg) begin
          gap_nxt   = 1'b1;
          kind_nxt  = swan_pkg::KIND_RETX;
          state_nxt = ST_G_END;
        end else begin
          kind_nxt       = swan_pkg::KIND_SEND;
          last_acked_nxt = seq_r;
          win_nxt        = clamp_win({1'b0, win_r} + 8'd1, min_win_r, max_win_r);
          state_nxt      = ST_S_D0A;
        end
      end
      ST_G_END: begin
        end_nxt   = alu_y[32:0];
        state_nxt = ST_G_B1;
      end
      ST_G_B1: begin
        b1_nxt    = alu_y[32:0];
        state_nxt = ST_G_HIA;
      end
      ST_G_HIA: begin
        t0_nxt    = alu_neg ? phi_a : {1'b0, b1_r};
        state_nxt = ST_G_LENA;
      end
      ST_G_LENA: begin
        len1_nxt   = alu_neg ? '0 : alu_y[32:0];
        start1_nxt = last_acked_r;
        state_nxt  = ST_G_LOB;
      end
      ST_G_LOB: begin
        start2_nxt = alu_neg ? last_acked_r : first_seq_r;
        state_nxt  = ST_G_HIB;
      end
      ST_G_HIB: begin
        t0_nxt    = alu_neg ? phi_b : {1'b0, b1_r};
        state_nxt = ST_G_LENB;
      end
      ST_G_LENB: begin
        len2_nxt  = alu_neg ? '0 : alu_y[32:0];
        state_nxt = ST_TOT;
      end
      ST_S_D0A: begin
        t0_nxt    = {2'b00, alu_y[31:0]};
        state_nxt = ST_S_D0B;
      end
      ST_S_D0B: begin
        // offset of the first candidate from the first data packet
        t0_nxt    = {2'b00, alu_y[31:0]};
        state_nxt = ST_S_END;
      end
      ST_S_END: begin
        end_nxt   = alu_y[32:0];
        state_nxt = ST_S_MIN;
      end
      ST_S_MIN: begin
        t1_nxt    = alu_neg ? phi_b : {2'b00, data_count_r};
        state_nxt = ST_S_LEN1;
      end
      ST_S_LEN1: begin
        len1_nxt  = alu_neg ? '0 : alu_y[32:0];
        state_nxt = ST_S_ST1;
      end
      ST_S_ST1: begin
        start1_nxt = alu_y[31:0];
        state_nxt  = ST_S_LEN2;
      end
      ST_S_LEN2: begin
        // wrapped part of the window, starting at the first data packet
        if (end_r[32]) begin
          len2_nxt = alu_neg ? {1'b0, end_r[31:0]} : {1'b0, data_count_r};
        end else begin
          len2_nxt = '0;
        end
        start2_nxt = first_seq_r;
        state_nxt  = ST_TOT;
      end
      ST_N_DIF: begin
        t0_nxt    = {2'b00, alu_y[31:0]};
        win_nxt   = clamp_win((win_r == '0) ? 8'd0 : {1'b0, win_r} - 8'd1,
                              min_win_r, max_win_r);
        state_nxt = ST_N_CHK;
      end
      ST_N_CHK: begin
        len1_nxt   = alu_neg ? swan_pkg::len_t'(1) : '0;
        len2_nxt   = '0;
        start1_nxt = seq_r;
        start2_nxt = seq_r;
        state_nxt  = ST_TOT;
      end
      ST_TOT: begin
        t1_nxt    = alu_y;
        state_nxt = ST_CAP;
      end
      ST_CAP: begin
        trunc_nxt     = alu_neg && gap_r;
        out_left_nxt  = n_sel;
        run1_left_nxt = (|len1_r[32:6]) ? swan_pkg::MAX_OUT : len1_r[6:0];
        cur_nxt       = (len1_r == '0) ? start2_r : start1_r;
        state_nxt     = (n_sel == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_seq_nxt   = cur_r;
          out_win_nxt   = win_r;
          out_trunc_nxt = trunc_r;
          out_last_nxt  = (out_left_r == 7'd1);
          out_left_nxt  = out_left_r - 7'd1;
          // advance within the first run, then jump to the second
          if (run1_left_r != '0) begin
            run1_left_nxt = run1_left_r - 7'd1;
            cur_nxt       = (run1_left_r == 7'd1) ? start2_r : cur_r + 32'd1;
          end else begin
            cur_nxt = cur_r + 32'd1;
          end
          if (out_left_r == 7'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_seq_r  <= 32'd1;
      data_count_r <= '0;
      min_win_r    <= 7'd1;
      max_win_r    <= 7'd32;
      last_acked_r <= swan_pkg::NONE_YET;
      win_r        <= '0;
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
    end else begin
      first_seq_r  <= first_seq_nxt;
      data_count_r <= data_count_nxt;
      min_win_r    <= min_win_nxt;
      max_win_r    <= max_win_nxt;
      last_acked_r <= last_acked_nxt;
      win_r        <= win_nxt;
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r       <= seq_nxt;
    kind_r      <= kind_nxt;
    gap_r       <= gap_nxt;
    trunc_r     <= trunc_nxt;
    t0_r        <= t0_nxt;
    t1_r        <= t1_nxt;
    end_r       <= end_nxt;
    b1_r        <= b1_nxt;
    len1_r      <= len1_nxt;
    len2_r      <= len2_nxt;
    start1_r    <= start1_nxt;
    start2_r    <= start2_nxt;
    cur_r       <= cur_nxt;
    out_left_r  <= out_left_nxt;
    run1_left_r <= run1_left_nxt;
    out_kind_r  <= out_kind_nxt;
    out_seq_r   <= out_seq_nxt;
    out_win_r   <= out_win_nxt;
    out_trunc_r <= out_trunc_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_request_kind = out_kind_r;
  assign out_request_seq  = out_seq_r;
  assign out_window_now   = out_win_r;
  assign out_truncated    = out_trunc_r;
  assign out_last         = out_last_r;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: sliding-window ACK/NAK controller
// Drives ACK, NAK and bad-kind events through the valid/stall input channel,
// predicts every send and retransmit request from a local copy of the window
// state and registers, and checks each accepted request field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_LIMIT  = 64;
  localparam int BURST_LIMIT   = 64;
  localparam int MAX_RESULTS   = 64;
  localparam int SETTLE_CYCLES = 30;
  localparam int ITEMS_PER_SET = 30;
  localparam int RANDOM_SETS   = 7;
  localparam longint unsigned SEQ_SPAN = 64'h1_0000_0000;

  // Event kinds the package leaves unnamed
  localparam swan_pkg::op_t OP_BAD_LO = 2'd2;
  localparam swan_pkg::op_t OP_BAD_HI = 2'd3;

  typedef struct {
    swan_pkg::kind_t kind;
    swan_pkg::seq_t  seq;
    swan_pkg::win_t  win;
    logic            trunc;
    logic            last;
  } request_t;

  class window_scoreboard;
    swan_pkg::seq_t first_seq;
    swan_pkg::seq_t data_count;
    swan_pkg::win_t min_win;
    swan_pkg::win_t max_win;
    swan_pkg::seq_t last_acked;
    swan_pkg::win_t window;
    request_t expected_q[$];
    request_t fresh[$];
    longint unsigned burst_total;
    int errors;

    function new();
      first_seq  = 32'd1;
      data_count = '0;
      min_win    = 7'd1;
      max_win    = 7'd32;
      last_acked = swan_pkg::NONE_YET;
      window     = '0;
      errors     = 0;
    endfunction

    function void write_reg(swan_pkg::cfg_idx_t idx, swan_pkg::seq_t value);
      case (idx)
        swan_pkg::CFG_FIRST_SEQ:  first_seq = value;
        swan_pkg::CFG_DATA_COUNT: data_count = value;
        swan_pkg::CFG_MIN_WIN:    min_win = value[swan_pkg::WIN_W-1:0];
        swan_pkg::CFG_MAX_WIN:    max_win = value[swan_pkg::WIN_W-1:0];
      endcase
    endfunction

    function bit exists(swan_pkg::seq_t s);
      swan_pkg::seq_t offset;
      offset = s - first_seq;
      return offset < data_count;
    endfunction

    function swan_pkg::win_t clamp(int unsigned w);
      int unsigned hi, lo;
      hi = max_win;
      lo = min_win;
      if (hi > WINDOW_LIMIT) hi = WINDOW_LIMIT;
      if (lo > hi) lo = hi;
      if (w > hi) return swan_pkg::win_t'(hi);
      if (w < lo) return swan_pkg::win_t'(lo);
      return swan_pkg::win_t'(w);
    endfunction

    function void add_request(swan_pkg::kind_t kind, swan_pkg::seq_t seq);
      request_t r;
      r.kind  = kind;
      r.seq   = seq;
      r.win   = window;
      r.trunc = 1'b0;
      r.last  = 1'b0;
      fresh = {fresh, r};
    endfunction

    // Retransmit the part of [last_acked, b] that lies in the linear span [plo, phi)
    function void retx_span(longint unsigned plo, longint unsigned phi, longint unsigned b);
      longint unsigned lo, hi;
      lo = (plo > last_acked) ? plo : last_acked;
      hi = (phi < b + 1) ? phi : b + 1;
      if (lo >= hi) return;
      burst_total += hi - lo;
      for (longint unsigned s = lo; s < hi && fresh.size() < BURST_LIMIT; s++)
        add_request(swan_pkg::KIND_RETX, swan_pkg::seq_t'(s));
    endfunction

    function void note_event(swan_pkg::op_t op, swan_pkg::seq_t seq);
      longint unsigned f, fin;
      fresh.delete();
      burst_total = 0;
      if (op == swan_pkg::OP_ACK) begin
        if (last_acked != swan_pkg::NONE_YET && seq != 0 && last_acked < seq - 1) begin
          // gap: state stays, data range may wrap past the top of the space
          f = first_seq;
          fin = f + data_count;
          if (fin > SEQ_SPAN) retx_span(0, fin - SEQ_SPAN, seq);
          retx_span(f, (fin < SEQ_SPAN) ? fin : SEQ_SPAN, seq);
          if (burst_total > BURST_LIMIT)
            foreach (fresh[i]) fresh[i].trunc = 1'b1;
        end else begin
          last_acked = seq;
          window = clamp(window + 1);
          for (int unsigned k = 1; k <= window && fresh.size() < MAX_RESULTS; k++)
            if (exists(last_acked + swan_pkg::seq_t'(k)))
              add_request(swan_pkg::KIND_SEND, last_acked + swan_pkg::seq_t'(k));
        end
      end else if (op == swan_pkg::OP_NAK) begin
        // saturate before the clamp
        window = clamp((window > 0) ? window - 1 : 0);
        if (exists(seq)) add_request(swan_pkg::KIND_RETX, seq);
      end else begin
        add_request(swan_pkg::KIND_BAD, '0);
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i]) expected_q = {expected_q, fresh[i]};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        if (errors < 100)
          $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(swan_pkg::kind_t kind, swan_pkg::seq_t seq,
                               swan_pkg::win_t win, logic trunc, logic last);
      request_t want;
      if (expected_q.size() == 0) begin
        if (errors < 100)
          $display("%0t: unexpected request: expected none actual kind %h seq %h",
                   $time, kind, seq);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("request_kind", 32'(want.kind), 32'(kind));
      compare_field("request_seq", want.seq, seq);
      compare_field("window_now", 32'(want.win), 32'(win));
      compare_field("truncated", 32'(want.trunc), 32'(trunc));
      compare_field("last", 32'(want.last), 32'(last));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  swan_pkg::op_t      in_operation = swan_pkg::OP_ACK;
  swan_pkg::seq_t     in_ack_seq = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  swan_pkg::kind_t    out_request_kind;
  swan_pkg::seq_t     out_request_seq;
  swan_pkg::win_t     out_window_now;
  logic               out_truncated;
  logic               out_last;
  logic               cfg_we = 1'b0;
  swan_pkg::cfg_idx_t cfg_index = swan_pkg::CFG_FIRST_SEQ;
  swan_pkg::seq_t     cfg_data = '0;

  bit idle_on = 1'b1;
  int stall_left = 0;
  window_scoreboard sb = new();

  sliding_window_ack_nak_control #(
    .WINDOW_LIMIT(WINDOW_LIMIT),
    .BURST_LIMIT (BURST_LIMIT)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_ack_seq      (in_ack_seq),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_request_kind(out_request_kind),
    .out_request_seq (out_request_seq),
    .out_window_now  (out_window_now),
    .out_truncated   (out_truncated),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Request sink: check accepted items, stall in random bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_request_kind, out_request_seq, out_window_now, out_truncated,
                      out_last);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_event(swan_pkg::op_t op, swan_pkg::seq_t seq);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_ack_seq <= seq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_event(op, seq);
  endtask

  // Drain every expected request, then give a no-result event time to finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(swan_pkg::seq_t first, swan_pkg::seq_t count,
                              swan_pkg::win_t min_w, swan_pkg::win_t max_w);
    swan_pkg::cfg_idx_t regs[4] = '{swan_pkg::CFG_FIRST_SEQ, swan_pkg::CFG_DATA_COUNT,
                                    swan_pkg::CFG_MIN_WIN, swan_pkg::CFG_MAX_WIN};
    swan_pkg::seq_t vals[4];
    vals = '{first, count, swan_pkg::seq_t'(min_w), swan_pkg::seq_t'(max_w)};
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    swan_pkg::seq_t first, count;
    swan_pkg::win_t min_w, max_w;
    case ($urandom_range(0, 3))
      0: first = '0;
      1: first = swan_pkg::NONE_YET - $urandom_range(0, 40);
      2: first = $urandom;
      default: first = $urandom_range(1, 1000);
    endcase
    case ($urandom_range(0, 9))
      0: count = '0;
      1: count = '1;
      2: count = $urandom;
      default: count = $urandom_range(1, 300);
    endcase
    min_w = ($urandom_range(0, 4) == 0) ? swan_pkg::win_t'($urandom_range(0, 127))
                                        : swan_pkg::win_t'($urandom_range(1, 16));
    max_w = ($urandom_range(0, 4) == 0) ? swan_pkg::win_t'($urandom_range(0, 127))
                                        : swan_pkg::win_t'($urandom_range(8, 64));
    write_config(first, count, min_w, max_w);
  endtask

  // Mostly walk the window forward from the last acked number, some rewinds and noise
  task automatic random_event();
    swan_pkg::seq_t base;
    int unsigned pick;
    if (sb.last_acked == swan_pkg::NONE_YET || $urandom_range(0, 4) == 0)
      base = sb.first_seq - 1 + $urandom_range(0, 20);
    else
      base = sb.last_acked;
    pick = $urandom_range(0, 99);
    if (pick < 45) send_event(swan_pkg::OP_ACK, base + 1);
    else if (pick < 55) send_event(swan_pkg::OP_ACK, base);
    else if (pick < 72) send_event(swan_pkg::OP_ACK, base + $urandom_range(2, 90));
    else if (pick < 85) send_event(swan_pkg::OP_NAK, base + $urandom_range(0, 80) - 8);
    else if (pick < 91) send_event(($urandom_range(0, 1) != 0) ? OP_BAD_HI : OP_BAD_LO,
                                   $urandom);
    else if (pick < 94) send_event(swan_pkg::OP_ACK, $urandom);
    else send_event(swan_pkg::OP_NAK, $urandom);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: no data exists; NAK at window zero saturates
    send_event(OP_BAD_LO, '0);
    send_event(OP_BAD_HI, '1);
    send_event(swan_pkg::OP_NAK, '0);
    send_event(swan_pkg::OP_ACK, 32'd5);
    settle();

    write_config(32'd1, 32'd1000, 7'd1, 7'd64);
    send_event(swan_pkg::OP_ACK, 32'd0);
    send_event(swan_pkg::OP_ACK, 32'd100);
    send_event(swan_pkg::OP_ACK, 32'd1);
    send_event(swan_pkg::OP_NAK, 32'd50);
    send_event(swan_pkg::OP_NAK, 32'd5000);
    send_event(swan_pkg::OP_ACK, 32'd40);
    send_event(swan_pkg::OP_ACK, 32'd0);
    send_event(swan_pkg::OP_ACK, swan_pkg::NONE_YET);
    settle();

    // data range wraps past the top of the sequence space
    write_config(32'hFFFF_FFF0, 32'd32, 7'd64, 7'd127);
    send_event(swan_pkg::OP_ACK, 32'hFFFF_FFF8);
    send_event(swan_pkg::OP_ACK, 32'd5);
    send_event(swan_pkg::OP_ACK, 32'hFFFF_FFFF);
    send_event(swan_pkg::OP_NAK, 32'hFFFF_FFF0);
    send_event(swan_pkg::OP_NAK, 32'h0000_0010);
    settle();

    // lower clamp above upper clamp, upper clamp zero
    write_config('0, '1, 7'd127, 7'd0);
    send_event(swan_pkg::OP_ACK, 32'd3);
    send_event(swan_pkg::OP_NAK, 32'd3);
    send_event(swan_pkg::OP_ACK, 32'd1000);
    settle();

    write_config('0, '1, 7'd64, 7'd64);
    send_event(swan_pkg::OP_ACK, 32'd4);
    send_event(swan_pkg::OP_NAK, swan_pkg::NONE_YET);
    send_event(swan_pkg::OP_ACK, 32'd4);
    settle();

    for (int set = 0; set < RANDOM_SETS; set++) begin
      idle_on = (set != RANDOM_SETS - 1) && (set % 3 != 2);
      random_config();
      for (int n = 0; n < ITEMS_PER_SET; n++) random_event();
      settle();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* sliding_window_ack_nak_control.f */
design/swan_pkg.sv
design/sliding_window_ack_nak_control.sv
tb/testbench.sv
